>>> sv/flat_triangle_span_walker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the span walker
// Clocked, reset-qualified property wrappers used by the controller (fts_ctrl).
// ----------------------------------------------------------------------------
`ifndef FLAT_TRIANGLE_SPAN_WALKER_MACROS_SVH
`define FLAT_TRIANGLE_SPAN_WALKER_MACROS_SVH

// condition holds at every edge out of reset
`define FTSW_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define FTSW_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, item codes and control structs of the span walker.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int COORD_BITS = 12;
  localparam int MINOR_BITS = COORD_BITS + 2;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 32;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [MINOR_BITS-1:0] minor_t;
  typedef logic [DEC_BITS-1:0]   dec_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic   kind;
    logic   flat_top;
    coord_t apex_x;
    coord_t apex_y;
    coord_t base_row;
    coord_t base_left_x;
    coord_t base_right_x;
    color_t fill_color;
  } fts_in_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic row_begin;
    logic walk;
    logic emit;
  } fts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic special;
    logic walk_done;
  } fts_sts_t;

endpackage

>>> sv/fts_if.sv
// ----------------------------------------------------------------------------
// fts channel interfaces
// Valid/ready channels for triangle items and span results.
// ----------------------------------------------------------------------------
interface fts_in_if
  import fts_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   kind;
  logic   flat_top;
  coord_t apex_x;
  coord_t apex_y;
  coord_t base_row;
  coord_t base_left_x;
  coord_t base_right_x;
  color_t fill_color;

  modport source (output valid, kind, flat_top, apex_x, apex_y, base_row,
                  base_left_x, base_right_x, fill_color, input ready);
  modport sink   (input valid, kind, flat_top, apex_x, apex_y, base_row,
                  base_left_x, base_right_x, fill_color, output ready);
endinterface

interface fts_out_if
  import fts_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t span_row;
  coord_t span_start_x;
  coord_t span_end_x;
  color_t span_color;
  logic   last_span;

  modport source (output valid, span_row, span_start_x, span_end_x, span_color,
                  last_span, input ready);
  modport sink   (input valid, span_row, span_start_x, span_end_x, span_color,
                  last_span, output ready);
endinterface

>>> sv/fts_edge.sv
// ----------------------------------------------------------------------------
// fts_edge
// One Bresenham edge: setup from its end points, then one pixel per cycle.
// ----------------------------------------------------------------------------
module fts_edge
  import fts_pkg::*;
(
  input  logic     clk,
  input  fts_cmd_t cmd,
  input  coord_t   x_start,
  input  coord_t   x_end,
  input  coord_t   dy,
  output coord_t   x,
  output logic     done,
  output coord_t   lo,
  output coord_t   hi
);

  localparam coord_t COORD_ONE = coord_t'(1);

  coord_t x_r;
  dec_t   d_r;
  minor_t minor2_r;
  dec_t   mmm_r;
  logic   incr_r;
  logic   xmaj_r;
  coord_t entry_r;
  coord_t last_r;
  logic   done_r;

  logic [COORD_BITS:0] dx_s;
  coord_t adx;
  logic   xmaj_s;
  coord_t mn;
  coord_t mj;
  dec_t   d_s;
  dec_t   mmm_s;
  minor_t minor2_s;
  coord_t x_step;
  dec_t   d_add_mmm;
  dec_t   d_add_minor;

  // setup arithmetic
  always_comb begin
    dx_s     = {1'b0, x_end} - {1'b0, x_start};
    adx      = dx_s[COORD_BITS] ? (~dx_s[COORD_BITS-1:0] + COORD_ONE)
                                : dx_s[COORD_BITS-1:0];
    xmaj_s   = adx > dy;
    mn       = xmaj_s ? dy : adx;
    mj       = xmaj_s ? adx : dy;
    minor2_s = {1'b0, mn, 1'b0};
    mmm_s    = {2'b00, mn, 1'b0} - {2'b00, mj, 1'b0};
    d_s      = {2'b00, mn, 1'b0} - {3'b000, mj};
  end

  // walk arithmetic
  always_comb begin
    x_step      = incr_r ? x_r + COORD_ONE : x_r - COORD_ONE;
    d_add_mmm   = d_r + mmm_r;
    d_add_minor = d_r + {1'b0, minor2_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x_r      <= x_start;
      d_r      <= d_s;
      minor2_r <= minor2_s;
      mmm_r    <= mmm_s;
      incr_r   <= x_end > x_start;
      xmaj_r   <= xmaj_s;
    end else if (cmd.row_begin) begin
      entry_r <= x_r;
      last_r  <= x_r;
      done_r  <= 1'b0;
    end else if (cmd.walk && !done_r) begin
      if (!d_r[DEC_BITS-1]) begin
        // decision crossed: take the row-change step and stop
        d_r    <= d_add_mmm;
        x_r    <= x_step;
        done_r <= 1'b1;
      end else begin
        d_r    <= d_add_minor;
        if (xmaj_r) begin
          x_r    <= x_step;
          last_r <= x_step;
        end else begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign x    = x_r;
  assign done = done_r;
  assign lo   = (entry_r < last_r) ? entry_r : last_r;
  assign hi   = (entry_r > last_r) ? entry_r : last_r;

endmodule

>>> sv/fts_datapath.sv
// ----------------------------------------------------------------------------
// fts_datapath
// Triangle registers, row counters, both edge walkers and the span register.
// ----------------------------------------------------------------------------
module fts_datapath
  import fts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  fts_cmd_t cmd,
  input  fts_in_t  in_item,
  output fts_sts_t sts,
  output coord_t   span_row,
  output coord_t   span_start_x,
  output coord_t   span_end_x,
  output color_t   span_color,
  output logic     last_span
);

  localparam coord_t COORD_ONE = coord_t'(1);

  logic   active_r;
  logic   top_r;
  logic   zero_r;
  coord_t apex_r;
  coord_t x0_r;
  coord_t x1_r;
  coord_t dy_r;
  coord_t cur_row_r;
  coord_t end_row_r;
  color_t color_r;

  coord_t out_row_r;
  coord_t out_lo_r;
  coord_t out_hi_r;
  color_t out_color_r;
  logic   out_last_r;

  logic   swap;
  logic   zero_s;
  logic   bad_s;
  logic   last_row;
  coord_t l_xs, l_xe, r_xs, r_xe;
  coord_t l_x, r_x, l_lo, l_hi, r_lo, r_hi;
  logic   l_done, r_done;
  coord_t span_lo, span_hi;

  always_comb begin
    swap   = in_item.base_left_x > in_item.base_right_x;
    zero_s = in_item.apex_y == in_item.base_row;
    bad_s  = in_item.flat_top ? (in_item.apex_y < in_item.base_row)
                              : (in_item.apex_y > in_item.base_row);
  end

  // edge end points: flat-top edges run from the base ends to the apex
  always_comb begin
    l_xs = (top_r || zero_r) ? x0_r : apex_r;
    l_xe = top_r ? apex_r : x0_r;
    r_xs = (top_r || zero_r) ? x1_r : apex_r;
    r_xe = top_r ? apex_r : x1_r;
  end

  fts_edge u_left (
    .clk     (clk),
    .cmd     (cmd),
    .x_start (l_xs),
    .x_end   (l_xe),
    .dy      (dy_r),
    .x       (l_x),
    .done    (l_done),
    .lo      (l_lo),
    .hi      (l_hi)
  );

  fts_edge u_right (
    .clk     (clk),
    .cmd     (cmd),
    .x_start (r_xs),
    .x_end   (r_xe),
    .dy      (dy_r),
    .x       (r_x),
    .done    (r_done),
    .lo      (r_lo),
    .hi      (r_hi)
  );

  assign last_row = cur_row_r == end_row_r;

  always_comb begin
    priority if (zero_r) begin
      span_lo = l_x;
      span_hi = r_x;
    end else if (top_r && last_row) begin
      // apex row: both edges close on the apex
      span_lo = (l_x < apex_r) ? l_x : apex_r;
      span_hi = (r_x > apex_r) ? r_x : apex_r;
    end else begin
      span_lo = l_lo;
      span_hi = r_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.load) begin
      active_r <= zero_s || !bad_s;
    end else if (cmd.emit && last_row) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_r     <= in_item.flat_top;
      zero_r    <= zero_s;
      apex_r    <= in_item.apex_x;
      x0_r      <= swap ? in_item.base_right_x : in_item.base_left_x;
      x1_r      <= swap ? in_item.base_left_x : in_item.base_right_x;
      dy_r      <= in_item.flat_top ? in_item.apex_y - in_item.base_row
                                    : in_item.base_row - in_item.apex_y;
      cur_row_r <= in_item.flat_top ? in_item.base_row : in_item.apex_y;
      end_row_r <= (in_item.flat_top || zero_s) ? in_item.apex_y
                                                : in_item.base_row - COORD_ONE;
      color_r   <= in_item.fill_color;
    end else if (cmd.emit && !last_row) begin
      cur_row_r <= cur_row_r + COORD_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cur_row_r;
      out_lo_r    <= span_lo;
      out_hi_r    <= span_hi;
      out_color_r <= color_r;
      out_last_r  <= last_row;
    end
  end

  assign sts.active    = active_r;
  assign sts.special   = zero_r || (top_r && last_row);
  assign sts.walk_done = l_done && r_done;

  assign span_row     = out_row_r;
  assign span_start_x = out_lo_r;
  assign span_end_x   = out_hi_r;
  assign span_color   = out_color_r;
  assign last_span    = out_last_r;

endmodule

>>> sv/fts_ctrl.sv
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer for load, edge setup, row walk and span hand-off.
// ----------------------------------------------------------------------------
module fts_ctrl
  import fts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  input  logic     out_ready,
  input  fts_sts_t sts,
  output logic     in_ready,
  output logic     out_valid,
  output fts_cmd_t cmd
);

  `include "flat_triangle_span_walker_macros.svh"

  typedef enum logic [1:0] {S_READY, S_SETUP, S_WALK, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   slot_free;

  assign in_ready  = state_r == S_READY;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_READY: begin
        if (in_fire) begin
          if (in_kind == KIND_START) begin
            cmd.load  = 1'b1;
            state_nxt = S_SETUP;
          end else if (sts.active) begin
            if (sts.special) begin
              state_nxt = S_EMIT;
            end else begin
              cmd.row_begin = 1'b1;
              state_nxt     = S_WALK;
            end
          end
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_READY;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold the span until the output register frees up
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_READY;
        end
      end
      default: state_nxt = S_READY;
    endcase
  end

  always_comb begin
    if (cmd.emit)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_READY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FTSW_IMPLY(a_load_then_setup, cmd.load, state_r == S_SETUP, "load not followed by setup")
  `FTSW_CHECK(a_walk_needs_active, !cmd.row_begin || sts.active, "row walk with no triangle")
  `FTSW_IMPLY(a_walk_exit, state_r == S_WALK && sts.walk_done, state_r == S_EMIT, "walk stuck")
  `FTSW_IMPLY(a_emit_shows, cmd.emit, out_valid_r, "emitted span not presented")

endmodule

>>> sv/flat_triangle_span_walker.sv
// ----------------------------------------------------------------------------
// flat_triangle_span_walker
// Scan-line span generator for one flat-top or flat-bottom triangle.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     carries
//  in_chan   in   valid/ready   start or step item
//  out_chan  out  valid/ready   one span per step of an active triangle
//
//  A start item is captured, then its edges are set up.
//  A step on a zero-height or apex row goes straight to the span hand-off;
//  otherwise both edge walkers first walk the row, one pixel a cycle in each
//  (a y-major edge walks a single pixel), until both have finished.
//  Reset is synchronous and clears control state only; no clearing pass.
//  A finished span waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module flat_triangle_span_walker
  import fts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fts_in_if.sink     in_chan,
  fts_out_if.source  out_chan
);

  fts_cmd_t cmd;
  fts_sts_t sts;
  fts_in_t  in_item;

  always_comb begin
    in_item.kind         = in_chan.kind;
    in_item.flat_top     = in_chan.flat_top;
    in_item.apex_x       = in_chan.apex_x;
    in_item.apex_y       = in_chan.apex_y;
    in_item.base_row     = in_chan.base_row;
    in_item.base_left_x  = in_chan.base_left_x;
    in_item.base_right_x = in_chan.base_right_x;
    in_item.fill_color   = in_chan.fill_color;
  end

  fts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  fts_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_item      (in_item),
    .sts          (sts),
    .span_row     (out_chan.span_row),
    .span_start_x (out_chan.span_start_x),
    .span_end_x   (out_chan.span_end_x),
    .span_color   (out_chan.span_color),
    .last_span    (out_chan.last_span)
  );

endmodule

>>> sim/fts_span_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fts_span_checker
// Watches both channels of the span walker, predicts the span of every
// accepted step from its own copy of the edge walkers, and compares each
// accepted span field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fts_span_checker
  import fts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fts_in_if    in_mon,
  fts_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int COORD_MASK = (1 << COORD_BITS) - 1;
  localparam int WALK_LIMIT = (1 << COORD_BITS) + 1;

  typedef struct packed {
    coord_t row;
    coord_t start_x;
    coord_t end_x;
    color_t color;
    logic   last;
  } span_t;

  typedef struct {
    int x;
    int dec;
    int minor2;
    int mmm;
    bit incr;
    bit xmaj;
  } edge_walk_t;

  bit         tri_active;
  bit         flat_span_mode;  // zero height: one span across the base
  bit         apex_row_mode;   // flat-top: last row closes on the apex
  int         cur_row;
  int         last_row;
  int         apex_col;
  color_t     tri_color;
  edge_walk_t left_e;
  edge_walk_t right_e;
  span_t      pending_spans[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic edge_walk_t edge_setup(int xs, int xe, int dy);
    edge_walk_t e;
    int dx;
    dx     = (xe > xs) ? xe - xs : xs - xe;
    e.x    = xs;
    e.incr = xe > xs;
    e.xmaj = dx > dy;
    if (e.xmaj) begin
      e.minor2 = 2 * dy;
      e.mmm    = 2 * dy - 2 * dx;
      e.dec    = 2 * dy - dx;
    end else begin
      e.minor2 = 2 * dx;
      e.mmm    = 2 * dx - 2 * dy;
      e.dec    = 2 * dx - dy;
    end
    return e;
  endfunction

  function automatic int step_x(int x, bit incr);
    return (incr ? x + 1 : x - 1) & COORD_MASK;
  endfunction

  // advance one row; lo/hi are the extreme x of the pixels left on this row
  function automatic void edge_walk(inout edge_walk_t e, output int lo, output int hi);
    int entry;
    int lastx;
    int n;
    entry = e.x;
    lastx = e.x;
    if (e.xmaj) begin
      for (n = 0; n < WALK_LIMIT; n++) begin
        if (e.dec >= 0) begin
          e.dec += e.mmm;
          e.x = step_x(e.x, e.incr);
          break;
        end
        e.dec += e.minor2;
        e.x = step_x(e.x, e.incr);
        lastx = e.x;
      end
    end else if (e.dec >= 0) begin
      e.dec += e.mmm;
      e.x = step_x(e.x, e.incr);
    end else begin
      e.dec += e.minor2;
    end
    lo = (entry < lastx) ? entry : lastx;
    hi = (entry > lastx) ? entry : lastx;
  endfunction

  function automatic void load_triangle(fts_in_t item);
    int x0;
    int x1;
    int ax;
    int ay;
    int by;
    int tmp;
    x0 = int'(item.base_left_x);
    x1 = int'(item.base_right_x);
    ax = int'(item.apex_x);
    ay = int'(item.apex_y);
    by = int'(item.base_row);
    if (x0 > x1) begin
      tmp = x0;
      x0  = x1;
      x1  = tmp;
    end
    tri_active     = 1'b0;
    flat_span_mode = 1'b0;
    apex_row_mode  = 1'b0;
    cur_row        = 0;
    last_row       = 0;
    left_e         = '{default: 0};
    right_e        = '{default: 0};
    tri_color      = item.fill_color;
    apex_col       = ax;
    if (ay == by) begin
      tri_active     = 1'b1;
      flat_span_mode = 1'b1;
      cur_row        = ay;
      last_row       = ay;
      left_e.x       = x0;
      right_e.x      = x1;
      return;
    end
    if (!item.flat_top) begin
      if (ay > by) return;
      left_e   = edge_setup(ax, x0, by - ay);
      right_e  = edge_setup(ax, x1, by - ay);
      cur_row  = ay;
      last_row = by - 1;
    end else begin
      if (ay < by) return;
      left_e        = edge_setup(x0, ax, ay - by);
      right_e       = edge_setup(x1, ax, ay - by);
      cur_row       = by;
      last_row      = ay;
      apex_row_mode = 1'b1;
    end
    tri_active = 1'b1;
  endfunction

  function automatic void next_span();
    span_t s;
    int lo;
    int hi;
    int unused;
    bit fin;
    if (!tri_active) return;
    fin = cur_row == last_row;
    if (flat_span_mode) begin
      lo = left_e.x;
      hi = right_e.x;
    end else if (apex_row_mode && fin) begin
      lo = (left_e.x < apex_col) ? left_e.x : apex_col;
      hi = (right_e.x > apex_col) ? right_e.x : apex_col;
    end else begin
      edge_walk(left_e, lo, unused);
      edge_walk(right_e, unused, hi);
    end
    s.row     = coord_t'(cur_row);
    s.start_x = coord_t'(lo);
    s.end_x   = coord_t'(hi);
    s.color   = tri_color;
    s.last    = fin;
    pending_spans.push_back(s);
    if (fin) tri_active = 1'b0;
    else cur_row = (cur_row + 1) & COORD_MASK;
  endfunction

  function automatic void check_span();
    span_t want;
    if (pending_spans.size() == 0) begin
      $error("unexpected span: row %0d, x %0d..%0d", out_mon.span_row,
             out_mon.span_start_x, out_mon.span_end_x);
      fail_count++;
      return;
    end
    want = pending_spans.pop_front();
    if (out_mon.span_row !== want.row) begin
      $error("span_row: expected %0d, got %0d", want.row, out_mon.span_row);
      fail_count++;
    end
    if (out_mon.span_start_x !== want.start_x) begin
      $error("span_start_x: expected %0d, got %0d", want.start_x, out_mon.span_start_x);
      fail_count++;
    end
    if (out_mon.span_end_x !== want.end_x) begin
      $error("span_end_x: expected %0d, got %0d", want.end_x, out_mon.span_end_x);
      fail_count++;
    end
    if (out_mon.span_color !== want.color) begin
      $error("span_color: expected %h, got %h", want.color, out_mon.span_color);
      fail_count++;
    end
    if (out_mon.last_span !== want.last) begin
      $error("last_span: expected %0d, got %0d", want.last, out_mon.last_span);
      fail_count++;
    end
  endfunction

  // compare the outgoing span first: a span leaving at this edge is never
  // caused by the transaction accepted at the same edge
  always @(posedge clk) begin : watch
    fts_in_t item;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) check_span();
      if (in_mon.valid && in_mon.ready) begin
        item.kind         = in_mon.kind;
        item.flat_top     = in_mon.flat_top;
        item.apex_x       = in_mon.apex_x;
        item.apex_y       = in_mon.apex_y;
        item.base_row     = in_mon.base_row;
        item.base_left_x  = in_mon.base_left_x;
        item.base_right_x = in_mon.base_right_x;
        item.fill_color   = in_mon.fill_color;
        if (item.kind == KIND_START) load_triangle(item);
        else next_span();
      end
    end
    pending = pending_spans.size();
  end

endmodule

>>> sim/tb_flat_triangle_span_walker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_flat_triangle_span_walker
// Feeds the span walker directed corner triangles, then random well-formed
// triangles mostly walked to their last span, broken and out-of-order
// sequences and raw noise, with random gaps on both channels. The span checker
// predicts and compares; this module decides the verdict.
// ----------------------------------------------------------------------------
module tb_flat_triangle_span_walker
  import fts_pkg::*;
;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   send_steady = 1'b0;

  fts_in_if  in_chan ();
  fts_out_if out_chan ();

  flat_triangle_span_walker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  fts_span_checker span_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("flat_triangle_span_walker test failed");
      $finish;
    end
  end

  function automatic fts_in_t start_item(logic top, int ax, int ay, int by,
                                         int x0, int x1, color_t color);
    fts_in_t item;
    item.kind         = KIND_START;
    item.flat_top     = top;
    item.apex_x       = coord_t'(ax);
    item.apex_y       = coord_t'(ay);
    item.base_row     = coord_t'(by);
    item.base_left_x  = coord_t'(x0);
    item.base_right_x = coord_t'(x1);
    item.fill_color   = color;
    return item;
  endfunction

  function automatic fts_in_t noise_item(logic kind);
    logic [95:0] bits;
    fts_in_t     item;
    bits      = {$urandom(), $urandom(), $urandom()};
    item      = bits[$bits(fts_in_t)-1:0];
    item.kind = kind;
    return item;
  endfunction

  function automatic int near_x(int ax, int reach);
    int v;
    v = ax + $urandom_range(0, 2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  function automatic int span_rows(fts_in_t item);
    int ay;
    int by;
    ay = int'(item.apex_y);
    by = int'(item.base_row);
    if (ay == by) return 1;
    if (!item.flat_top) return (ay < by) ? by - ay : 0;
    return (ay > by) ? ay - by + 1 : 0;
  endfunction

  // mostly short triangles with bases near the apex; some wide x-major ones
  function automatic fts_in_t shaped_triangle();
    int   dy;
    int   ax;
    int   ay;
    int   by;
    int   reach;
    logic top;
    top   = 1'($urandom_range(0, 1));
    dy    = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 15);
    reach = ($urandom_range(0, 7) == 0) ? 600 : 40;
    ax    = $urandom_range(0, COORD_MAX);
    if (!top) begin
      ay = $urandom_range(0, COORD_MAX - dy);
      by = ay + dy;
    end else begin
      by = $urandom_range(0, COORD_MAX - dy);
      ay = by + dy;
    end
    return start_item(top, ax, ay, by, near_x(ax, reach), near_x(ax, reach), $urandom());
  endfunction

  task automatic send_item(input fts_in_t item);
    int gap;
    if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.kind         <= item.kind;
    in_chan.flat_top     <= item.flat_top;
    in_chan.apex_x       <= item.apex_x;
    in_chan.apex_y       <= item.apex_y;
    in_chan.base_row     <= item.base_row;
    in_chan.base_left_x  <= item.base_left_x;
    in_chan.base_right_x <= item.base_right_x;
    in_chan.fill_color   <= item.fill_color;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_item(noise_item(KIND_STEP));
  endtask

  // result side: stall a random number of cycles ahead of every span
  initial begin : span_sink
    int stall;
    bit steady;
    steady = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    fts_in_t shape;
    int      counted;
    int      pick;
    int      rows;
    int      steps;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.kind         <= KIND_START;
    in_chan.flat_top     <= 1'b0;
    in_chan.apex_x       <= '0;
    in_chan.apex_y       <= '0;
    in_chan.base_row     <= '0;
    in_chan.base_left_x  <= '0;
    in_chan.base_right_x <= '0;
    in_chan.fill_color   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // step with nothing loaded
    send_steps(1);
    // zero height with swapped base ends, then a step past the end
    send_item(start_item(1'b0, COORD_MAX, 100, 100, 300, 200, 32'h0000_0000));
    send_steps(2);
    // one row, right edge runs across the whole width
    send_item(start_item(1'b0, 0, 0, 1, 0, COORD_MAX, 32'hA5A5_5A5A));
    send_steps(1);
    // flat-top ending on the bottom row, apex left of the base
    send_item(start_item(1'b1, 0, COORD_MAX, COORD_MAX - 2, COORD_MAX, COORD_MAX - 5,
                         32'hFFFF_FFFF));
    send_steps(3);
    // rows in the wrong order load nothing
    send_item(start_item(1'b0, 20, 50, 10, 5, 40, 32'h1234_5678));
    send_steps(1);
    send_item(start_item(1'b1, 20, 10, 50, 5, 40, 32'h8765_4321));
    send_steps(1);
    // full-height triangle, interrupted by a new start
    send_item(start_item(1'b0, COORD_MAX / 2 + 1, 0, COORD_MAX, 0, COORD_MAX, 32'h0F0F_F0F0));
    send_steps(2);
    send_item(start_item(1'b0, 7, COORD_MAX, COORD_MAX, COORD_MAX, 0, 32'hFFFF_FFFF));
    send_steps(1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        shape = shaped_triangle();
        rows  = span_rows(shape);
        steps = rows;
        if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, rows);
        else if ($urandom_range(0, 5) == 0) steps = rows + $urandom_range(1, 2);
      end else if (pick < 18) begin
        shape          = shaped_triangle();
        shape.flat_top = !shape.flat_top;
        steps          = $urandom_range(0, 2);
      end else begin
        shape = noise_item(KIND_START);
        steps = $urandom_range(0, 3);
      end
      send_item(shape);
      send_steps(steps);
      rows    = span_rows(shape);
      counted += 1 + ((steps < rows) ? steps : rows);
    end
    in_chan.valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("flat_triangle_span_walker test passed");
    end else begin
      $display("flat_triangle_span_walker test failed");
    end
    $finish;
  end

endmodule
